// ===== hdl/aekf_pkg.sv =====
package aekf_pkg;

   localparam int POS_W   = 20;
   localparam int SCORE_W = 17;
   localparam int HOLD_W  = 8;
   localparam int CSR_W   = 24;
   localparam int MUL_W   = 29;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = 90;

   typedef logic signed [MUL_W-1:0]  mul_op_type;
   typedef logic signed [PROD_W-1:0] mul_prod_type;

   localparam logic [SCORE_W-1:0] ALPHA_ONE  = 17'd65536;
   localparam logic [SCORE_W-1:0] ALPHA_CAP  = 17'd13107;
   localparam logic [SCORE_W-1:0] LOW_SCORE  = 17'd19661;
   localparam logic [19:0]        DEFAULT_DT = 20'd33333;
   // 10^12 = 5^12 * 2^12; the power of two is applied as a shift.
   localparam logic [27:0]        FIVE_POW12 = 28'd244140625;

   localparam logic [2:0] CSR_HOLD_ENABLE     = 3'd0;
   localparam logic [2:0] CSR_MAX_HOLD        = 3'd1;
   localparam logic [2:0] CSR_ALPHA_GOOD      = 3'd2;
   localparam logic [2:0] CSR_ALPHA_LOW_CONF  = 3'd3;
   localparam logic [2:0] CSR_ALPHA_RECOVERED = 3'd4;
   localparam logic [2:0] CSR_ALPHA_INVALID   = 3'd5;
   localparam logic [2:0] CSR_MAX_DEPTH_JUMP  = 3'd6;
   localparam logic [2:0] CSR_MAX_SPEED       = 3'd7;

   localparam logic [3:0] RC_INIT        = 4'd0;
   localparam logic [3:0] RC_RAW_INVALID = 4'd1;
   localparam logic [3:0] RC_HOLD        = 4'd2;
   localparam logic [3:0] RC_EXPIRED     = 4'd3;
   localparam logic [3:0] RC_GOOD        = 4'd4;
   localparam logic [3:0] RC_LOW_CONF    = 4'd5;
   localparam logic [3:0] RC_RECOVERED   = 4'd6;
   localparam logic [3:0] RC_DEPTH_JUMP  = 4'd7;
   localparam logic [3:0] RC_SPEED_JUMP  = 4'd8;
   localparam logic [3:0] RC_JOINT_INIT  = 4'd9;

endpackage

// ===== hdl/aekf_ram.sv =====
module aekf_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/aekf_mul.sv =====
module aekf_mul (
   input  logic                  clock,
   input  logic                  en,
   input  aekf_pkg::mul_op_type  op_a,
   input  aekf_pkg::mul_op_type  op_b,
   output aekf_pkg::mul_prod_type prod
);
   import aekf_pkg::*;

   mul_prod_type prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
      end
   end

   assign prod = prod_ff;

endmodule

// ===== hdl/adaptive_ema_keypoint_filter_top.sv =====
// A joint sample's result is registered in DONE and offered in OUT after the RUN steps.
// A new sample is taken only in IDLE, after the last result is taken; clear and out-of-range
// beats start no run. A sample's 13 products go one per cycle through a single 29x29 multiplier.
// Reset is synchronous: control and CSR registers return to their defaults, and the joint table reads as
// zero through per-joint valid bits cleared at once, so no clearing pass is needed.
module adaptive_ema_keypoint_filter_top #(
   parameter int JOINTS = 22
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [4:0]  req_joint_index,
   input  logic        req_frame_end,
   input  logic signed [19:0] req_pos_x,
   input  logic signed [19:0] req_pos_y,
   input  logic signed [19:0] req_pos_z,
   input  logic [16:0] req_score,
   input  logic        req_sample_valid,
   input  logic        req_recovered,
   input  logic [19:0] req_frame_dt_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_out_joint,
   output logic signed [19:0] rsp_out_x,
   output logic signed [19:0] rsp_out_y,
   output logic signed [19:0] rsp_out_z,
   output logic [16:0] rsp_out_score,
   output logic        rsp_out_valid,
   output logic [16:0] rsp_alpha_used,
   output logic [3:0]  rsp_reason_code,
   output logic [7:0]  rsp_hold_count
);
   import aekf_pkg::*;

   localparam int AW      = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int ENTRY_W = 3 * POS_W + SCORE_W + 1 + HOLD_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   // Destination of the product leaving the multiplier.
   localparam logic [3:0] T_NONE   = 4'd0;
   localparam logic [3:0] T_LIM    = 4'd1;
   localparam logic [3:0] T_D2_SET = 4'd2;
   localparam logic [3:0] T_D2_ADD = 4'd3;
   localparam logic [3:0] T_SET44  = 4'd4;
   localparam logic [3:0] T_ADD23  = 4'd5;
   localparam logic [3:0] T_ADD0   = 4'd6;
   localparam logic [3:0] T_SUB12  = 4'd7;
   localparam logic [3:0] T_SUB33  = 4'd8;
   localparam logic [3:0] T_BX     = 4'd9;
   localparam logic [3:0] T_BY     = 4'd10;
   localparam logic [3:0] T_BZ     = 4'd11;
   localparam logic [3:0] T_BS     = 4'd12;

   localparam logic [3:0] STEP_ALPHA = 4'd10;
   localparam logic [3:0] STEP_LAST  = 4'd15;

   function automatic logic [SCORE_W-1:0] sat_alpha(input logic [SCORE_W-1:0] a);
      return (a > ALPHA_ONE) ? ALPHA_ONE : a;
   endfunction

   function automatic logic [POS_W-1:0] blend_pos(input logic signed [POS_W-1:0] p,
                                                  input mul_prod_type m);
      logic signed [39:0] s;
      s = (40'(p) <<< 16) + 40'sd32768 + 40'(m);
      return s[35:16];
   endfunction

   function automatic logic [SCORE_W-1:0] blend_score(input logic [SCORE_W-1:0] p,
                                                      input mul_prod_type m);
      logic signed [39:0] s;
      s = (40'($signed({1'b0, p})) <<< 16) + 40'sd32768 + 40'(m);
      return s[32:16];
   endfunction

   // Configuration registers.
   logic        hold_en_ff;
   logic [7:0]  max_hold_ff;
   logic [16:0] a_good_ff, a_low_ff, a_rec_ff, a_inv_ff;
   logic [18:0] max_dz_ff;
   logic [23:0] max_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_en_ff   <= 1'b1;
         max_hold_ff  <= 8'd5;
         a_good_ff    <= 17'd32768;
         a_low_ff     <= 17'd19661;
         a_rec_ff     <= 17'd13107;
         a_inv_ff     <= 17'd0;
         max_dz_ff    <= 19'd9830;
         max_speed_ff <= 24'd196608;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HOLD_ENABLE:     hold_en_ff   <= csr_wdata[0];
            CSR_MAX_HOLD:        max_hold_ff  <= csr_wdata[7:0];
            CSR_ALPHA_GOOD:      a_good_ff    <= csr_wdata[16:0];
            CSR_ALPHA_LOW_CONF:  a_low_ff     <= csr_wdata[16:0];
            CSR_ALPHA_RECOVERED: a_rec_ff     <= csr_wdata[16:0];
            CSR_ALPHA_INVALID:   a_inv_ff     <= csr_wdata[16:0];
            CSR_MAX_DEPTH_JUMP:  max_dz_ff    <= csr_wdata[18:0];
            CSR_MAX_SPEED:       max_speed_ff <= csr_wdata[23:0];
            default:             hold_en_ff   <= hold_en_ff;
         endcase
      end
   end

   // Control.
   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [JOINTS-1:0] jv_ff;
   logic       have_frame_ff;
   logic       accept, in_range;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign accept    = req_valid && req_ready;
   assign in_range  = (int'(req_joint_index) < JOINTS);

   // Latched sample.
   logic [4:0]             in_joint_ff;
   logic                   in_fend_ff, in_sv_ff, in_rec_ff;
   logic signed [POS_W-1:0] in_x_ff, in_y_ff, in_z_ff;
   logic [SCORE_W-1:0]     in_score_ff;
   logic [19:0]            in_dt_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         in_joint_ff <= req_joint_index;
         in_fend_ff  <= req_frame_end;
         in_sv_ff    <= req_sample_valid;
         in_rec_ff   <= req_recovered;
         in_x_ff     <= req_pos_x;
         in_y_ff     <= req_pos_y;
         in_z_ff     <= req_pos_z;
         in_score_ff <= req_score;
         in_dt_ff    <= req_frame_dt_us;
      end
   end

   // Joint table.
   logic [AW-1:0]      j_addr;
   logic [ENTRY_W-1:0] rd_entry, wr_entry;
   logic               wr_en;

   assign j_addr = AW'(in_joint_ff);
   assign wr_en  = (state_ff == ST_DONE);

   aekf_ram #(.WIDTH(ENTRY_W), .DEPTH(JOINTS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (j_addr),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (AW'(req_joint_index)),
      .rd_data (rd_entry)
   );

   logic [ENTRY_W-1:0]      prev_entry;
   logic signed [POS_W-1:0] p_x, p_y, p_z;
   logic [SCORE_W-1:0]      p_score;
   logic                    p_valid;
   logic [HOLD_W-1:0]       p_hc;

   // A joint never written since reset or clear reads as all zero.
   assign prev_entry = jv_ff[j_addr] ? rd_entry : '0;
   assign {p_x, p_y, p_z, p_score, p_valid, p_hc} = prev_entry;

   // Differences against the stored joint.
   logic signed [20:0] dx, dy, dz;
   logic signed [17:0] ds;
   logic [20:0]        adx, ady, adz;
   logic [19:0]        dt_eff;

   assign dx  = 21'(in_x_ff) - 21'(p_x);
   assign dy  = 21'(in_y_ff) - 21'(p_y);
   assign dz  = 21'(in_z_ff) - 21'(p_z);
   assign ds  = $signed({1'b0, in_score_ff}) - $signed({1'b0, p_score});
   assign adx = dx[20] ? 21'(-dx) : 21'(dx);
   assign ady = dy[20] ? 21'(-dy) : 21'(dy);
   assign adz = dz[20] ? 21'(-dz) : 21'(dz);
   assign dt_eff = (in_dt_ff == 20'd0) ? DEFAULT_DT : in_dt_ff;

   // Shared multiplier sequencing.
   logic [43:0]        lim_ff;
   logic [41:0]        d2_ff;
   logic signed [ACC_W-1:0] acc_ff, prod_ext;
   logic [3:0]         tag, tag_ff;
   mul_op_type         op_a, op_b;
   mul_prod_type       prod;
   logic [16:0]        al_ff;
   logic [3:0]         rcv_ff;
   logic signed [POS_W-1:0] bx_ff, by_ff, bz_ff;
   logic [SCORE_W-1:0] bs_ff;

   always_comb begin
      op_a = '0;
      op_b = '0;
      tag  = T_NONE;
      unique case (step_ff)
         4'd0: begin
            op_a = mul_op_type'(max_speed_ff); op_b = mul_op_type'(dt_eff); tag = T_LIM;
         end
         4'd1: begin
            op_a = mul_op_type'(adx); op_b = mul_op_type'(adx); tag = T_D2_SET;
         end
         4'd2: begin
            op_a = mul_op_type'(ady); op_b = mul_op_type'(ady); tag = T_D2_ADD;
         end
         4'd3: begin
            op_a = mul_op_type'(adz); op_b = mul_op_type'(adz); tag = T_D2_ADD;
         end
         4'd4: begin
            op_a = mul_op_type'(lim_ff[43:22]); op_b = mul_op_type'(lim_ff[43:22]);
            tag  = T_SET44;
         end
         4'd5: begin
            op_a = mul_op_type'(lim_ff[43:22]); op_b = mul_op_type'(lim_ff[21:0]);
            tag  = T_ADD23;
         end
         4'd6: begin
            op_a = mul_op_type'(lim_ff[21:0]); op_b = mul_op_type'(lim_ff[21:0]);
            tag  = T_ADD0;
         end
         4'd7: begin
            op_a = mul_op_type'(d2_ff[20:0]); op_b = mul_op_type'(FIVE_POW12); tag = T_SUB12;
         end
         4'd8: begin
            op_a = mul_op_type'(d2_ff[41:21]); op_b = mul_op_type'(FIVE_POW12); tag = T_SUB33;
         end
         4'd11: begin
            op_a = mul_op_type'(al_ff); op_b = mul_op_type'(dx); tag = T_BX;
         end
         4'd12: begin
            op_a = mul_op_type'(al_ff); op_b = mul_op_type'(dy); tag = T_BY;
         end
         4'd13: begin
            op_a = mul_op_type'(al_ff); op_b = mul_op_type'(dz); tag = T_BZ;
         end
         4'd14: begin
            op_a = mul_op_type'(al_ff); op_b = mul_op_type'(ds); tag = T_BS;
         end
         default: tag = T_NONE;
      endcase
   end

   aekf_mul u_mul (
      .clock (clock),
      .en    (state_ff == ST_RUN),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign prod_ext = ACC_W'(prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= T_NONE;
      end else begin
         tag_ff <= (state_ff == ST_RUN) ? tag : T_NONE;
      end
   end

   // The accumulator ends up holding lim^2 - d2 * 10^12; negative means too fast.
   always_ff @(posedge clock) begin
      unique case (tag_ff)
         T_LIM:    lim_ff <= prod[43:0];
         T_D2_SET: d2_ff  <= prod[41:0];
         T_D2_ADD: d2_ff  <= d2_ff + prod[41:0];
         T_SET44:  acc_ff <= prod_ext <<< 44;
         T_ADD23:  acc_ff <= acc_ff + (prod_ext <<< 23);
         T_ADD0:   acc_ff <= acc_ff + prod_ext;
         T_SUB12:  acc_ff <= acc_ff - (prod_ext <<< 12);
         T_SUB33:  acc_ff <= acc_ff - (prod_ext <<< 33);
         T_BX:     bx_ff  <= blend_pos(p_x, prod);
         T_BY:     by_ff  <= blend_pos(p_y, prod);
         T_BZ:     bz_ff  <= blend_pos(p_z, prod);
         T_BS:     bs_ff  <= blend_score(p_score, prod);
         default:  lim_ff <= lim_ff;
      endcase
   end

   // Alpha selection once the speed test is complete.
   logic [16:0] al_sel;
   logic [3:0]  rc_sel;

   always_comb begin
      if (in_rec_ff) begin
         al_sel = sat_alpha(a_rec_ff);
         rc_sel = RC_RECOVERED;
      end else if (in_score_ff < LOW_SCORE) begin
         al_sel = sat_alpha(a_low_ff);
         rc_sel = RC_LOW_CONF;
      end else begin
         al_sel = sat_alpha(a_good_ff);
         rc_sel = RC_GOOD;
      end
      if (adz > 21'(max_dz_ff)) begin
         al_sel = (al_sel > ALPHA_CAP) ? ALPHA_CAP : al_sel;
         rc_sel = RC_DEPTH_JUMP;
      end else if (acc_ff[ACC_W-1]) begin
         al_sel = (al_sel > ALPHA_CAP) ? ALPHA_CAP : al_sel;
         rc_sel = RC_SPEED_JUMP;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RUN && step_ff == STEP_ALPHA) begin
         al_ff  <= al_sel;
         rcv_ff <= rc_sel;
      end
   end

   // Final result selection.
   logic signed [POS_W-1:0] o_x, o_y, o_z;
   logic [SCORE_W-1:0]      o_s;
   logic                    o_v;
   logic [16:0]             o_al;
   logic [3:0]              o_rc;
   logic [HOLD_W-1:0]       o_hc, new_hc;

   always_comb begin
      o_x    = in_x_ff;
      o_y    = in_y_ff;
      o_z    = in_z_ff;
      o_s    = in_score_ff;
      o_v    = in_sv_ff;
      o_hc   = '0;
      new_hc = p_hc;
      if (!have_frame_ff) begin
         o_al = in_sv_ff ? ALPHA_ONE : 17'd0;
         o_rc = in_sv_ff ? RC_INIT : RC_RAW_INVALID;
         if (in_sv_ff) begin
            new_hc = '0;
         end
      end else if (!in_sv_ff) begin
         o_al = sat_alpha(a_inv_ff);
         if (hold_en_ff && p_valid && p_hc < max_hold_ff) begin
            o_x    = p_x;
            o_y    = p_y;
            o_z    = p_z;
            o_s    = p_score;
            o_v    = 1'b1;
            new_hc = p_hc + 8'd1;
            o_rc   = RC_HOLD;
         end else begin
            o_v  = 1'b0;
            o_rc = RC_EXPIRED;
         end
         o_hc = new_hc;
      end else begin
         new_hc = '0;
         o_v    = 1'b1;
         if (!p_valid) begin
            o_al = ALPHA_ONE;
            o_rc = RC_JOINT_INIT;
         end else begin
            o_x  = bx_ff;
            o_y  = by_ff;
            o_z  = bz_ff;
            o_s  = bs_ff;
            o_al = al_ff;
            o_rc = rcv_ff;
         end
      end
   end

   assign wr_entry = {o_x, o_y, o_z, o_s, o_v, new_hc};

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         rsp_out_joint   <= in_joint_ff;
         rsp_out_x       <= o_x;
         rsp_out_y       <= o_y;
         rsp_out_z       <= o_z;
         rsp_out_score   <= o_s;
         rsp_out_valid   <= o_v;
         rsp_alpha_used  <= o_al;
         rsp_reason_code <= o_rc;
         rsp_hold_count  <= o_hc;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept && !req_operation && in_range) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 4'd1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         jv_ff         <= '0;
         have_frame_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (accept && req_operation) begin
            jv_ff         <= '0;
            have_frame_ff <= 1'b0;
         end else if (accept && !in_range && req_frame_end) begin
            have_frame_ff <= 1'b1;
         end else if (state_ff == ST_DONE) begin
            jv_ff[j_addr] <= 1'b1;
            if (in_fend_ff) begin
               have_frame_ff <= 1'b1;
            end
         end
      end
   end

`ifndef ASSERT_OFF
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result sides open at once");

   a_hold_usable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reason_code == RC_HOLD) |-> rsp_out_valid)
      else $error("held joint reported unusable");

   a_expired_unusable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reason_code == RC_EXPIRED) |-> !rsp_out_valid)
      else $error("expired joint reported usable");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && step_ff == 4'd0) |-> $past(state_ff) == ST_IDLE)
      else $error("sequence started without an accepted beat");
`endif

endmodule
